/* rtl/core/rsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/sphere intersection package
// Shared widths, payload structs, register indexes and latency helpers.
// ----------------------------------------------------------------------------
package rsi_pkg;

	// Coordinate and register widths.
	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int RAD_W   = 31;
	localparam int ADDR_W  = 4;

	// Widths of the quadratic terms, all exact.
	localparam int DD_W = 64;
	localparam int DM_W = 65;
	localparam int MM_W = 65;
	localparam int RR_W = 62;
	localparam int A_W  = 64;
	localparam int H_W  = 66;
	localparam int C_W  = 67;
	localparam int Q_W  = 132;
	localparam int S_W  = 66;
	localparam int N_W  = 67;

	// Latency of the chunked multiplier.
	localparam int MUL_LAT = 4;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} reg_idx_t;

	// One ray request.
	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	// One intersection result.
	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} result_t;

	// Root selection flags handed to the solver.
	typedef struct packed {
		logic ok;
		logic hpos;
		logic cpos;
		logic cneg;
	} root_flags_t;

	// Solver latency: input stage, square root stages, root select, divide stages.
	function automatic int solve_lat(input int frac);
		return S_W + 2 + N_W + frac;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/ray_sphere_intersection_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/sphere intersection core
// Fixed-point ray/sphere hit test returning the nearest positive hit point.
// ----------------------------------------------------------------------------
// Usage:
//   Rays enter on the request channel (req_valid, req_stall, req) and one
//   result per ray leaves on the response channel (rsp_valid, rsp_stall,
//   rsp), in order. The sphere center and radius are set through the APB
//   port while no ray is in flight; pready is always high.
//   Throughput is one ray per cycle while no response is stalled. The
//   latency from request acceptance to rsp_valid is set by the square
//   root pipeline (one root bit per stage) and the divider pipeline (one
//   quotient bit per stage) plus the multiplier stages.
//   When the receiver stalls a valid response, every stage holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and loads center 0 and radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_core import rsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ray_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output result_t           rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int T_W       = N_W + FRAC_BITS;
	localparam int SOLVE_LAT = solve_lat(FRAC_BITS);
	localparam int PM_W      = COORD_W + T_W + 1;
	localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic                     en;
	logic signed [COORD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [RAD_W-1:0]         radius_q;
	reg_idx_t                 reg_idx;

	// Configuration registers.
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RAD_W'(65536);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_CENTER_X: center_x_q <= pwdata;
				REG_CENTER_Y: center_y_q <= pwdata;
				REG_CENTER_Z: center_z_q <= pwdata;
				REG_RADIUS:   radius_q   <= pwdata[RAD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X: prdata = center_x_q;
			REG_CENTER_Y: prdata = center_y_q;
			REG_CENTER_Z: prdata = center_z_q;
			REG_RADIUS:   prdata = {1'b0, radius_q};
		endcase
	end

	// The whole pipeline advances unless a finished result is held.
	assign en        = !rsp_valid || !rsp_stall;
	assign req_stall = !en;

	// Stage 1: offset from ray origin to sphere center.
	logic signed [COORD_W-1:0] org_c [3];
	logic signed [COORD_W-1:0] cen_c [3];
	ray_t                      ray_s1;
	logic signed [DIFF_W-1:0]  m_s1 [3];
	logic                      v_s1;

	always_comb begin
		org_c[0] = req.origin_x;
		org_c[1] = req.origin_y;
		org_c[2] = req.origin_z;
		cen_c[0] = center_x_q;
		cen_c[1] = center_y_q;
		cen_c[2] = center_z_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= req;
			for (int i = 0; i < 3; i++) begin
				m_s1[i] <= DIFF_W'(cen_c[i]) - DIFF_W'(org_c[i]);
			end
		end
	end

	// Stage 2: per-axis products and the squared radius.
	logic signed [COORD_W-1:0] dir1_c [3];
	logic signed [DD_W-1:0]    dd_c [3];
	logic signed [DM_W-1:0]    dm_c [3];
	logic signed [MM_W:0]      mm_c [3];
	logic [DD_W-1:0]           dd_s2 [3];
	logic signed [DM_W-1:0]    dm_s2 [3];
	logic [MM_W-1:0]           mm_s2 [3];
	logic [RR_W-1:0]           rr_s2;
	ray_t                      ray_s2;
	logic                      v_s2;

	always_comb begin
		dir1_c[0] = ray_s1.dir_x;
		dir1_c[1] = ray_s1.dir_y;
		dir1_c[2] = ray_s1.dir_z;
		for (int i = 0; i < 3; i++) begin
			dd_c[i] = dir1_c[i] * dir1_c[i];
			dm_c[i] = dir1_c[i] * m_s1[i];
			mm_c[i] = m_s1[i] * m_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= dd_c[i];
				dm_s2[i] <= dm_c[i];
				mm_s2[i] <= mm_c[i][MM_W-1:0];
			end
			rr_s2  <= radius_q * radius_q;
			ray_s2 <= ray_s1;
		end
	end

	// Stage 3: quadratic coefficients a = D.D, h = D.M, c = M.M - R^2.
	logic [A_W-1:0]          a_s3;
	logic signed [H_W-1:0]   h_s3;
	logic signed [C_W-1:0]   c_s3;
	logic signed [A_W:0]     a_ext_s3;
	root_flags_t             flags_s3;
	ray_t                    ray_s3;
	logic                    v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			h_s3   <= H_W'(dm_s2[0]) + H_W'(dm_s2[1]) + H_W'(dm_s2[2]);
			c_s3   <= $signed(C_W'(mm_s2[0]) + C_W'(mm_s2[1]) + C_W'(mm_s2[2])
			                  - C_W'(rr_s2));
			ray_s3 <= ray_s2;
		end
	end

	always_comb begin
		a_ext_s3      = $signed({1'b0, a_s3});
		flags_s3.ok   = a_s3 != '0;
		flags_s3.hpos = !h_s3[H_W-1] && (h_s3 != '0);
		flags_s3.cpos = !c_s3[C_W-1] && (c_s3 != '0);
		flags_s3.cneg = c_s3[C_W-1];
	end

	// Discriminant products h*h and a*c.
	logic signed [Q_W-1:0] hh, ac;

	rsi_mul #(.AW(H_W), .BW(H_W)) u_mul_hh (
		.clk (clk),
		.en  (en),
		.a   (h_s3),
		.b   (h_s3),
		.p   (hh)
	);

	rsi_mul #(.AW(A_W + 1), .BW(C_W)) u_mul_ac (
		.clk (clk),
		.en  (en),
		.a   (a_ext_s3),
		.b   (c_s3),
		.p   (ac)
	);

	// Side data riding along the discriminant multipliers.
	logic signed [H_W-1:0]   mw_h [MUL_LAT];
	logic [A_W-1:0]          mw_a [MUL_LAT];
	root_flags_t             mw_flags [MUL_LAT];
	ray_t                    mw_ray [MUL_LAT];
	logic [MUL_LAT-1:0]      mw_v;

	always_ff @(posedge clk) begin
		if (en) begin
			mw_h[0]     <= h_s3;
			mw_a[0]     <= a_s3;
			mw_flags[0] <= flags_s3;
			mw_ray[0]   <= ray_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				mw_h[i]     <= mw_h[i-1];
				mw_a[i]     <= mw_a[i-1];
				mw_flags[i] <= mw_flags[i-1];
				mw_ray[i]   <= mw_ray[i-1];
			end
		end
	end

	// Stage 4: discriminant and the final validity of the request.
	logic signed [Q_W-1:0]   q_c;
	root_flags_t             flags_c;
	logic signed [Q_W-1:0]   q_s4;
	logic signed [H_W-1:0]   h_s4;
	logic [A_W-1:0]          a_s4;
	root_flags_t             flags_s4;
	ray_t                    ray_s4;
	logic                    v_s4;

	always_comb begin
		q_c        = hh - ac;
		flags_c    = mw_flags[MUL_LAT-1];
		flags_c.ok = mw_flags[MUL_LAT-1].ok && !q_c[Q_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4     <= q_c;
			h_s4     <= mw_h[MUL_LAT-1];
			a_s4     <= mw_a[MUL_LAT-1];
			flags_s4 <= flags_c;
			ray_s4   <= mw_ray[MUL_LAT-1];
		end
	end

	// Square root, root choice and division down to the ray parameter.
	logic [T_W-1:0] t_sol;
	logic           hit_sol;

	rsi_solve #(.FRAC_BITS(FRAC_BITS)) u_solve (
		.clk   (clk),
		.en    (en),
		.q     (q_s4),
		.h     (h_s4),
		.a     (a_s4),
		.flags (flags_s4),
		.t     (t_sol),
		.hit   (hit_sol)
	);

	ray_t                 sw_ray [SOLVE_LAT];
	logic [SOLVE_LAT-1:0] sw_v;

	always_ff @(posedge clk) begin
		if (en) begin
			sw_ray[0] <= ray_s4;
			for (int i = 1; i < SOLVE_LAT; i++) begin
				sw_ray[i] <= sw_ray[i-1];
			end
		end
	end

	// Stage 5: direction times ray parameter on each axis.
	logic signed [T_W:0]   t_ext;
	logic signed [PM_W-1:0] pm [3];

	assign t_ext = $signed({1'b0, t_sol});

	rsi_mul #(.AW(COORD_W), .BW(T_W + 1)) u_mul_px (
		.clk (clk),
		.en  (en),
		.a   (sw_ray[SOLVE_LAT-1].dir_x),
		.b   (t_ext),
		.p   (pm[0])
	);

	rsi_mul #(.AW(COORD_W), .BW(T_W + 1)) u_mul_py (
		.clk (clk),
		.en  (en),
		.a   (sw_ray[SOLVE_LAT-1].dir_y),
		.b   (t_ext),
		.p   (pm[1])
	);

	rsi_mul #(.AW(COORD_W), .BW(T_W + 1)) u_mul_pz (
		.clk (clk),
		.en  (en),
		.a   (sw_ray[SOLVE_LAT-1].dir_z),
		.b   (t_ext),
		.p   (pm[2])
	);

	ray_t               pw_ray [MUL_LAT];
	logic [MUL_LAT-1:0] pw_hit;
	logic [MUL_LAT-1:0] pw_v;

	always_ff @(posedge clk) begin
		if (en) begin
			pw_ray[0] <= sw_ray[SOLVE_LAT-1];
			pw_hit    <= {pw_hit[MUL_LAT-2:0], hit_sol};
			for (int i = 1; i < MUL_LAT; i++) begin
				pw_ray[i] <= pw_ray[i-1];
			end
		end
	end

	// Stage 6: scale back, add the origin and saturate, or zero the point on a miss.
	logic signed [COORD_W-1:0] org5_c [3];
	logic signed [PM_W-1:0]    shr_c [3];
	logic signed [PM_W:0]      sum_c [3];
	logic [PM_W-COORD_W+1:0]   top_c [3];
	logic [COORD_W-1:0]        pt_c [3];
	result_t                   rsp_s6;
	ray_t                      ray_s6;
	logic                      v_s6;

	always_comb begin
		org5_c[0] = pw_ray[MUL_LAT-1].origin_x;
		org5_c[1] = pw_ray[MUL_LAT-1].origin_y;
		org5_c[2] = pw_ray[MUL_LAT-1].origin_z;
		for (int i = 0; i < 3; i++) begin
			shr_c[i] = pm[i] >>> FRAC_BITS;
			sum_c[i] = (PM_W+1)'(org5_c[i]) + (PM_W+1)'(shr_c[i]);
			top_c[i] = sum_c[i][PM_W:COORD_W-1];
			if (!pw_hit[MUL_LAT-1]) begin
				pt_c[i] = '0;
			end else if ((&top_c[i]) || !(|top_c[i])) begin
				pt_c[i] = sum_c[i][COORD_W-1:0];
			end else begin
				pt_c[i] = sum_c[i][PM_W] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s6.hit     <= pw_hit[MUL_LAT-1];
			rsp_s6.point_x <= pt_c[0];
			rsp_s6.point_y <= pt_c[1];
			rsp_s6.point_z <= pt_c[2];
			ray_s6         <= pw_ray[MUL_LAT-1];
		end
	end

	// Valid bits travel with the data and clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			mw_v <= '0;
			v_s4 <= 1'b0;
			sw_v <= '0;
			pw_v <= '0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			mw_v <= {mw_v[MUL_LAT-2:0], v_s3};
			v_s4 <= mw_v[MUL_LAT-1];
			sw_v <= {sw_v[SOLVE_LAT-2:0], v_s4};
			pw_v <= {pw_v[MUL_LAT-2:0], sw_v[SOLVE_LAT-1]};
			v_s6 <= pw_v[MUL_LAT-1];
		end
	end

	assign rsp_valid = v_s6;
	assign rsp       = rsp_s6;

	// A miss always reports the origin point of all zeros.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |->
			(rsp.point_x == '0) && (rsp.point_y == '0) && (rsp.point_z == '0))
		else $error("miss with nonzero point");

	// A ray with zero direction can never report a hit.
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |->
			(ray_s6.dir_x != '0) || (ray_s6.dir_y != '0) || (ray_s6.dir_z != '0))
		else $error("hit reported for zero direction");

	// A held pipeline keeps the discriminant stage frozen.
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && req_stall |=> $stable(q_s4) && $stable(flags_s4) && v_s4)
		else $error("discriminant stage moved while held");

endmodule
`default_nettype wire

/* rtl/core/rsi_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked signed multiplier
// Signed product split into 32x32 partial products over four register stages.
// ----------------------------------------------------------------------------
module rsi_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int PW = AW + BW;
	localparam int RW = 32 * NB + 32;
	localparam int FW = 32 * (NA + NB);

	logic [AW:0]        ext_a, abs_a;
	logic [BW:0]        ext_b, abs_b;
	logic [32*NA-1:0]   mag_a_s1;
	logic [32*NB-1:0]   mag_b_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [63:0]        pp_s2 [NA][NB];
	logic [RW-1:0]      row_c [NA];
	logic [RW-1:0]      row_s3 [NA];
	logic [FW-1:0]      sum_c;
	logic [PW-1:0]      p_s4;

	// Magnitudes of both operands.
	always_comb begin
		ext_a = {a[AW-1], a};
		ext_b = {b[BW-1], b};
		abs_a = a[AW-1] ? (~ext_a + 1'b1) : ext_a;
		abs_b = b[BW-1] ? (~ext_b + 1'b1) : ext_b;
	end

	// Each row adds the partial products of one chunk of a.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (32 * j));
			end
		end
	end

	// The rows are added into the full magnitude.
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (FW'(row_s3[i]) << (32 * i));
		end
	end

	// Pipeline registers.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1 <= (32*NA)'(abs_a[AW-1:0]);
			mag_b_s1 <= (32*NB)'(abs_b[BW-1:0]);
			neg_s1   <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= mag_a_s1[32*i +: 32] * mag_b_s1[32*j +: 32];
				end
			end
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++) begin
				row_s3[i] <= row_c[i];
			end
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? PW'(~sum_c + 1'b1) : PW'(sum_c);
		end
	end

	assign p = $signed(p_s4);

endmodule
`default_nettype wire

/* rtl/core/rsi_solve.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray parameter solver
// Pipelined integer square root, root selection and restoring divider.
// ----------------------------------------------------------------------------
module rsi_solve import rsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [Q_W-1:0]       q,
	input  logic signed [H_W-1:0]       h,
	input  logic [A_W-1:0]              a,
	input  root_flags_t                 flags,
	output logic [N_W+FRAC_BITS-1:0]    t,
	output logic                        hit
);

	localparam int NUM_W = N_W + FRAC_BITS;

	// Square root pipeline, one result bit per stage.
	logic [S_W+1:0]          sq_rem   [S_W+1];
	logic [S_W-1:0]          sq_root  [S_W+1];
	logic [Q_W-1:0]          sq_rad   [S_W+1];
	logic signed [H_W-1:0]   sq_h     [S_W+1];
	logic [A_W-1:0]          sq_a     [S_W+1];
	root_flags_t             sq_flags [S_W+1];

	// Divider pipeline, one quotient bit per stage.
	logic [NUM_W-1:0]        dv_num [NUM_W+1];
	logic [NUM_W-1:0]        dv_quo [NUM_W+1];
	logic [A_W:0]            dv_rem [NUM_W+1];
	logic [A_W-1:0]          dv_a   [NUM_W+1];
	logic                    dv_hit [NUM_W+1];

	logic signed [N_W:0]     h_ext, s_ext, n_c;

	// Input stage of the square root.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem[0]   <= '0;
			sq_root[0]  <= '0;
			sq_rad[0]   <= q;
			sq_h[0]     <= h;
			sq_a[0]     <= a;
			sq_flags[0] <= flags;
		end
	end

	// Each stage brings down two radicand bits and tries one root bit.
	for (genvar k = 0; k < S_W; k++) begin : g_sq
		logic [S_W+3:0] rin;
		logic [S_W+3:0] trial;
		logic           ge;

		always_comb begin
			rin   = {sq_rem[k], sq_rad[k][Q_W-1 -: 2]};
			trial = (S_W+4)'({sq_root[k], 2'b01});
			ge    = rin >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[k+1]   <= ge ? (S_W+2)'(rin - trial) : (S_W+2)'(rin);
				sq_root[k+1]  <= {sq_root[k][S_W-2:0], ge};
				sq_rad[k+1]   <= sq_rad[k] << 2;
				sq_h[k+1]     <= sq_h[k];
				sq_a[k+1]     <= sq_a[k];
				sq_flags[k+1] <= sq_flags[k];
			end
		end
	end

	// Nearer root when both h and c are positive, else the farther one.
	always_comb begin
		h_ext = (N_W+1)'(sq_h[S_W]);
		s_ext = $signed((N_W+1)'(sq_root[S_W]));
		n_c   = (sq_flags[S_W].hpos && sq_flags[S_W].cpos) ? (h_ext - s_ext)
		                                                   : (h_ext + s_ext);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_num[0] <= {n_c[N_W-1:0], {FRAC_BITS{1'b0}}};
			dv_quo[0] <= '0;
			dv_rem[0] <= '0;
			dv_a[0]   <= sq_a[S_W];
			dv_hit[0] <= sq_flags[S_W].ok && (sq_flags[S_W].hpos || sq_flags[S_W].cneg);
		end
	end

	// Restoring division of the scaled numerator by a.
	for (genvar k = 0; k < NUM_W; k++) begin : g_dv
		logic [A_W:0] rin;
		logic [A_W:0] dvs;
		logic         ge;

		always_comb begin
			rin = {dv_rem[k][A_W-1:0], dv_num[k][NUM_W-1]};
			dvs = {1'b0, dv_a[k]};
			ge  = rin >= dvs;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[k+1] <= ge ? (rin - dvs) : rin;
				dv_num[k+1] <= dv_num[k] << 1;
				dv_quo[k+1] <= {dv_quo[k][NUM_W-2:0], ge};
				dv_a[k+1]   <= dv_a[k];
				dv_hit[k+1] <= dv_hit[k];
			end
		end
	end

	assign t   = dv_quo[NUM_W];
	assign hit = dv_hit[NUM_W];

endmodule
`default_nettype wire
